[hdl/pbrd_pkg.sv]
// Shared types and constants for the PackBits row decoder.
// Used by the parser, the command queue, the element assembler and the top level.
package pbrd_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_ROW_BYTES     = 2'd0;
  localparam logic [1:0] CFG_ELEMENT_BYTES = 2'd1;

  // Stream constants
  localparam logic [7:0]  FLAG_SKIP       = 8'h80;
  localparam logic [15:0] WIDE_PREFIX_MIN = 16'd250;
  localparam logic [15:0] RAW_LIMIT       = 16'd8;

  // Command from the parser to the element assembler
  typedef enum logic {
    CMD_HIGH = 1'b0,  // latch first byte of a two-byte element
    CMD_EMIT = 1'b1   // produce one result word
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;     // element byte, or low byte of a two-byte element
    logic        wide;     // join with the latched high byte
    logic [7:0]  count;    // repeat count, 0 for a row marker
    logic        row_end;
  } cmd_t;

endpackage

[hdl/pbrd_parser.sv]
// Front part of the PackBits row decoder: tracks row prefix, flags, packets and
// raw elements one byte at a time and issues commands. Depends on pbrd_pkg.
module pbrd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      row_bytes,
  input  logic [1:0]       element_bytes,
  input  logic             byte_valid,
  input  logic [7:0]       data_byte,
  output logic             cmd_valid,
  output pbrd_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    PH_PREFIX    = 3'd0,
    PH_PREFIX_LO = 3'd1,
    PH_FLAG      = 3'd2,
    PH_RUN       = 3'd3,
    PH_LIT       = 3'd4,
    PH_RAW       = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic [16:0] bytes_left, bytes_left_next;
  logic [7:0]  literals_left, literals_left_next;
  logic [7:0]  run_length, run_length_next;
  logic [7:0]  prefix_hi, prefix_hi_next;
  logic        byte_phase, byte_phase_next;

  logic [16:0] left_dec;
  logic [7:0]  lit_dec;
  logic [15:0] row_len;
  logic        done;

  assign left_dec = (bytes_left == 17'd0) ? 17'd0 : bytes_left - 17'd1;
  assign lit_dec  = (literals_left == 8'd0) ? 8'd0 : literals_left - 8'd1;
  assign row_len  = (phase == PH_PREFIX_LO) ? {prefix_hi, data_byte} : {8'd0, data_byte};

  always_comb begin
    phase_next         = phase;
    bytes_left_next    = bytes_left;
    literals_left_next = literals_left;
    run_length_next    = run_length;
    prefix_hi_next     = prefix_hi;
    byte_phase_next    = byte_phase;
    done               = 1'b0;
    cmd_valid          = 1'b0;
    cmd.kind           = pbrd_pkg::CMD_EMIT;
    cmd.data           = 8'd0;
    cmd.wide           = 1'b0;
    cmd.count          = 8'd0;
    cmd.row_end        = 1'b1;

    unique case (phase)
      PH_FLAG: begin
        bytes_left_next = left_dec;
        if (data_byte == pbrd_pkg::FLAG_SKIP) begin
          // skip flag closes the row only when it uses up the length
          if (left_dec == 17'd0) begin
            phase_next = PH_PREFIX;
            cmd_valid  = 1'b1;
          end
        end else begin
          byte_phase_next = 1'b0;
          if (data_byte[7]) begin
            run_length_next = 8'(9'd257 - {1'b0, data_byte});
            phase_next      = PH_RUN;
          end else begin
            literals_left_next = data_byte + 8'd1;
            phase_next         = PH_LIT;
          end
        end
      end

      PH_RUN, PH_LIT, PH_RAW: begin
        bytes_left_next = left_dec;
        if (element_bytes[1] && !byte_phase) begin
          cmd_valid       = 1'b1;
          cmd.kind        = pbrd_pkg::CMD_HIGH;
          cmd.data        = data_byte;
          cmd.row_end     = 1'b0;
          byte_phase_next = 1'b1;
        end else begin
          byte_phase_next = 1'b0;
          cmd_valid       = 1'b1;
          cmd.data        = data_byte;
          cmd.wide        = byte_phase;
          cmd.count       = (phase == PH_RUN) ? run_length : 8'd1;
          if (phase == PH_LIT) begin
            literals_left_next = lit_dec;
            done               = (lit_dec == 8'd0);
          end else begin
            done = 1'b1;
          end
          cmd.row_end = done && (left_dec == 17'd0);
          if (cmd.row_end) begin
            phase_next = PH_PREFIX;
          end else if (done && phase != PH_RAW) begin
            phase_next = PH_FLAG;
          end
        end
      end

      PH_PREFIX_LO: begin
        bytes_left_next = {1'b0, row_len};
        byte_phase_next = 1'b0;
        if (row_len == 16'd0) begin
          phase_next = PH_PREFIX;
          cmd_valid  = 1'b1;
        end else begin
          phase_next = (row_bytes < pbrd_pkg::RAW_LIMIT) ? PH_RAW : PH_FLAG;
        end
      end

      default: begin
        // expect length prefix; unused codes behave the same
        if (row_bytes > pbrd_pkg::WIDE_PREFIX_MIN) begin
          prefix_hi_next = data_byte;
          phase_next     = PH_PREFIX_LO;
        end else begin
          bytes_left_next = {1'b0, row_len};
          byte_phase_next = 1'b0;
          if (row_len == 16'd0) begin
            phase_next = PH_PREFIX;
            cmd_valid  = 1'b1;
          end else begin
            phase_next = (row_bytes < pbrd_pkg::RAW_LIMIT) ? PH_RAW : PH_FLAG;
          end
        end
      end
    endcase

    if (!byte_valid) begin
      cmd_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_PREFIX;
      bytes_left    <= 17'd0;
      literals_left <= 8'd0;
      run_length    <= 8'd0;
      prefix_hi     <= 8'd0;
      byte_phase    <= 1'b0;
    end else if (byte_valid) begin
      phase         <= phase_next;
      bytes_left    <= bytes_left_next;
      literals_left <= literals_left_next;
      run_length    <= run_length_next;
      prefix_hi     <= prefix_hi_next;
      byte_phase    <= byte_phase_next;
    end
  end

endmodule

[hdl/pbrd_queue.sv]
// Command queue between the parser and the element assembler.
// Depends on pbrd_pkg for the command type.
module pbrd_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  pbrd_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           rd_en,
  output logic           rd_valid,
  output pbrd_pkg::cmd_t rd_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  pbrd_pkg::cmd_t   store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_cmd;
    end
  end

endmodule

[hdl/pbrd_assembler.sv]
// Back part of the PackBits row decoder: joins two-byte elements and holds the
// result word for the receiver. Depends on pbrd_pkg.
module pbrd_assembler (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  pbrd_pkg::cmd_t cmd,
  output logic           cmd_take,
  output logic           empty,
  input  logic           pop,
  output logic [15:0]    elem_value,
  output logic [7:0]     repeat_count,
  output logic           row_end
);

  logic       out_valid;
  logic [7:0] high_byte;
  logic       emit;

  assign cmd_take = cmd_valid && (!out_valid || pop);
  assign emit     = cmd_take && (cmd.kind == pbrd_pkg::CMD_EMIT);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && cmd.kind == pbrd_pkg::CMD_HIGH) begin
      high_byte <= cmd.data;
    end
    if (emit) begin
      elem_value   <= cmd.wide ? {high_byte, cmd.data} : {8'd0, cmd.data};
      repeat_count <= cmd.count;
      row_end      <= cmd.row_end;
    end
  end

endmodule

[hdl/packbits_row_decoder_top.sv]
// Top level of the PackBits row decoder: configuration registers, parser,
// command queue and element assembler. Depends on pbrd_pkg and its submodules.
// Usage:
//   Input channel: drive data_byte and raise push; a byte is taken at a rising
//   edge where push is high and full is low. Each row is a length prefix (two
//   bytes big-endian when row_bytes exceeds 250, else one byte), then packed
//   bytes: raw elements when row_bytes is below 8, PackBits packets otherwise.
//   Result channel: while empty is low, elem_value, repeat_count and row_end
//   show the oldest word; it is taken at a rising edge where pop is high.
//   Runs come out as one word with their count, literals with count 1, and a
//   word with count 0 is a bare end-of-row marker.
//   Configuration: write row_bytes (index 0) or element_bytes (index 1) with
//   cfg_we, cfg_index and cfg_data while no word is in flight.
//   Throughput: one byte per cycle while full is low; the parser steps once per
//   byte, and the assembler drains one command per cycle while pop is high.
//   Path: a command is written to the queue at the edge that takes its byte,
//   and the assembler then loads its word into the output register.
//   Receiver stall: the assembler holds its word, commands pile up in the
//   QUEUE_DEPTH-entry queue, and full rises once the queue fills.
//   Reset: rst (synchronous) clears the queue, drops the output word, returns
//   the parser to the row prefix and sets row_bytes 0, element_bytes 1.
module packbits_row_decoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] elem_value,
  output logic [7:0]  repeat_count,
  output logic        row_end
);

  logic [15:0]    row_bytes;
  logic [1:0]     element_bytes;
  logic           accept;
  logic           cmd_valid;
  pbrd_pkg::cmd_t cmd;
  logic           q_valid;
  pbrd_pkg::cmd_t q_cmd;
  logic           q_take;

  // Take a byte only when the queue has room for the command it may produce
  assign accept = push && !full;

  // Configuration registers; ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes     <= 16'd0;
      element_bytes <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pbrd_pkg::CFG_ROW_BYTES:     row_bytes     <= cfg_data;
        pbrd_pkg::CFG_ELEMENT_BYTES: element_bytes <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Front: classify each byte and issue commands
  pbrd_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .row_bytes     (row_bytes),
    .element_bytes (element_bytes),
    .byte_valid    (accept),
    .data_byte     (data_byte),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd)
  );

  // Decouple front and back so each can stall on its own
  pbrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cmd_valid),
    .wr_cmd   (cmd),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd)
  );

  // Back: join element bytes and present result words
  pbrd_assembler u_assembler (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (q_valid),
    .cmd          (q_cmd),
    .cmd_take     (q_take),
    .empty        (empty),
    .pop          (pop),
    .elem_value   (elem_value),
    .repeat_count (repeat_count),
    .row_end      (row_end)
  );

endmodule

[hdl/pbrd_checker.sv]
// Port-level checks for the PackBits row decoder, bound to the top level.
// Depends only on the top level's ports.
module pbrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [15:0] elem_value,
  input logic [7:0]  repeat_count,
  input logic        row_end
);

  // Reset leaves no word waiting and room for input
  assert property (@(posedge clk) rst |=> empty && !full)
    else $error("reset did not clear the channels");

  // A word without an element is an end-of-row marker with value zero
  assert property (@(posedge clk) disable iff (rst)
    (!empty && repeat_count == 8'd0) |-> (row_end && elem_value == 16'd0))
    else $error("marker word carries data or lacks row end");

  // Runs never exceed 128 repeats
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (repeat_count <= 8'd128))
    else $error("repeat count out of range");

  // A stalled word holds
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(elem_value) && $stable(repeat_count)
                          && $stable(row_end)))
    else $error("stalled word changed");

endmodule

bind packbits_row_decoder_top pbrd_checker u_pbrd_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .elem_value   (elem_value),
  .repeat_count (repeat_count),
  .row_end      (row_end)
);

[sim/packbits_row_decoder_top_tb.sv]
// Self-checking testbench for packbits_row_decoder_top: drives packed row streams
// into the byte input channel and checks every decoded word against a predictor.
// Depends on pbrd_pkg and the RTL top level only.
module packbits_row_decoder_top_tb;

  // Indexes the block must ignore
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  localparam int NUM_PHASES  = 12;
  localparam int PHASE_BYTES = 70;
  localparam int SHOW_LIMIT  = 10;
  localparam int SETTLE      = 8;   // cycles to let the parser and queue go quiet

  // Parser states of the decoder, as the predictor tracks them
  typedef enum logic [2:0] {
    ST_PREFIX, ST_PREFIX_LO, ST_FLAG, ST_RUN, ST_LIT, ST_RAW
  } parse_st_t;

  // One decoded word as it shows on the result ports
  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  count;
    logic        last;
  } word_t;

  // Predictor plus the queue of decoded words still owed by the block
  class packbits_predictor;
    logic [15:0] row_len_cfg;
    logic [1:0]  elem_width_cfg;
    parse_st_t   st;
    logic [16:0] owed;       // packed bytes still due in the row, stops at zero
    logic [7:0]  lits_owed;
    logic [7:0]  run_len;
    logic [7:0]  hold_byte;  // prefix high byte or first byte of a wide element
    logic        half;
    word_t       words_due[$];
    int          errors;
    int          bytes_seen;
    int          words_seen;
    int          rows_closed;

    function new();
      row_len_cfg    = '0;
      elem_width_cfg = 2'd1;
      st             = ST_PREFIX;
      owed           = '0;
      lits_owed      = '0;
      run_len        = '0;
      hold_byte      = '0;
      half           = 1'b0;
      errors         = 0;
      bytes_seen     = 0;
      words_seen     = 0;
      rows_closed    = 0;
    endfunction

    function int pending();
      return words_due.size();
    endfunction

    function void predict(logic [15:0] v, logic [7:0] c, logic e);
      word_t w;
      w.value = v;
      w.count = c;
      w.last  = e;
      words_due = {words_due, w};
    endfunction

    function void open_row(logic [15:0] len);
      owed = {1'b0, len};
      half = 1'b0;
      if (owed == '0) begin
        st = ST_PREFIX;
        predict(16'h0000, 8'd0, 1'b1);
      end else begin
        st = (row_len_cfg < pbrd_pkg::RAW_LIMIT) ? ST_RAW : ST_FLAG;
      end
    endfunction

    function void take_byte(logic [7:0] b);
      logic [15:0] v;
      logic [7:0]  c;
      logic        done;
      bytes_seen++;
      if (st == ST_FLAG || st == ST_RUN || st == ST_LIT || st == ST_RAW) begin
        if (owed != '0) owed = owed - 17'd1;
      end
      case (st)
        ST_PREFIX_LO: open_row({hold_byte, b});
        ST_FLAG: begin
          if (b == pbrd_pkg::FLAG_SKIP) begin
            // a skip flag only speaks up when it uses the row up
            if (owed == '0) begin
              st = ST_PREFIX;
              predict(16'h0000, 8'd0, 1'b1);
            end
          end else begin
            half = 1'b0;
            if (b[7]) begin
              run_len = 8'(9'd257 - {1'b0, b});
              st = ST_RUN;
            end else begin
              lits_owed = b + 8'd1;
              st = ST_LIT;
            end
          end
        end
        ST_RUN, ST_LIT, ST_RAW: begin
          if (elem_width_cfg >= 2'd2 && !half) begin
            hold_byte = b;
            half = 1'b1;
          end else begin
            v    = half ? {hold_byte, b} : {8'h00, b};
            half = 1'b0;
            c    = 8'd1;
            done = 1'b1;
            if (st == ST_RUN) begin
              c = run_len;
            end else if (st == ST_LIT) begin
              if (lits_owed != 8'd0) lits_owed = lits_owed - 8'd1;
              done = (lits_owed == 8'd0);
            end
            if (done && owed == '0) begin
              st = ST_PREFIX;
              predict(v, c, 1'b1);
            end else begin
              if (done && st != ST_RAW) st = ST_FLAG;
              predict(v, c, 1'b0);
            end
          end
        end
        default: begin
          st = ST_PREFIX;
          if (row_len_cfg > pbrd_pkg::WIDE_PREFIX_MIN) begin
            hold_byte = b;
            st = ST_PREFIX_LO;
          end else begin
            open_row({8'h00, b});
          end
        end
      endcase
    endfunction

    function void match_word(logic [15:0] v, logic [7:0] c, logic e);
      word_t w;
      words_seen++;
      if (e) rows_closed++;
      if (words_due.size() == 0) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("%0t: word value %h count %0d end %b arrived with none predicted",
                   $time, v, c, e);
        return;
      end
      w = words_due.pop_front();
      if (w.value !== v || w.count !== c || w.last !== e) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("%0t: mismatch: predicted value %h count %0d end %b, got %h %0d %b",
                   $time, w.value, w.count, w.last, v, c, e);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        empty;
  logic        pop;
  logic [15:0] elem_value;
  logic [7:0]  repeat_count;
  logic        row_end;

  packbits_predictor sb;
  logic [7:0]  stream_q[$];  // bytes built for the current phase, not yet pushed
  logic [15:0] cur_rows;     // configuration as the stimulus builder sees it
  logic [1:0]  cur_eb;
  logic        quiet;        // no gaps on either side while set
  int          settings_used;

  packbits_row_decoder_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .empty        (empty),
    .pop          (pop),
    .elem_value   (elem_value),
    .repeat_count (repeat_count),
    .row_end      (row_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Append one byte to the stream being built.
  function automatic void add_byte(logic [7:0] b);
    stream_q = {stream_q, b};
  endfunction

  // Write one register; drop the enable at the next falling edge.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Program both registers; junk in the upper bits of element_bytes must be masked.
  task automatic set_config(logic [15:0] rows, logic [1:0] eb);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(pbrd_pkg::CFG_ROW_BYTES, rows);
    write_reg(pbrd_pkg::CFG_ELEMENT_BYTES, {junk[15:2], eb});
    sb.row_len_cfg    = rows;
    sb.elem_width_cfg = eb;
    cur_rows = rows;
    cur_eb   = eb;
    settings_used++;
  endtask

  // Wait until every predicted word is out, then let the pipeline settle
  // since a trailing byte may have produced no word at all.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Push the built stream; hold each byte until the queue takes it.
  task automatic send_stream();
    logic [7:0] b;
    int         gap;
    while (stream_q.size() > 0) begin
      b   = stream_q.pop_front();
      gap = idle_len();
      if (gap > 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      push      <= 1'b1;
      data_byte <= b;
      @(posedge clk);
      while (full) @(posedge clk);
      sb.take_byte(b);
    end
    @(negedge clk);
    push <= 1'b0;
  endtask

  // Build one well-formed row for the current setting: prefix, then raw
  // elements or PackBits packets with random content. A literal packet may
  // run past the row length now and then.
  task automatic build_row();
    int len, used, ew, cap, n, r, k;
    ew = (cur_eb >= 2'd2) ? 2 : 1;
    r  = $urandom_range(0, 99);
    if (r < 5) len = 0;
    else if (r < 85) len = $urandom_range(1, 24);
    else if (r < 97) len = $urandom_range(25, 80);
    else if (cur_rows > pbrd_pkg::WIDE_PREFIX_MIN) len = $urandom_range(256, 400);
    else len = $urandom_range(200, 255);
    if (cur_rows > pbrd_pkg::WIDE_PREFIX_MIN) add_byte(8'(len >> 8));
    add_byte(8'(len));
    used = 0;
    if (cur_rows < pbrd_pkg::RAW_LIMIT) begin
      // raw: whole elements, so an odd length with wide elements overruns by one
      while (used < len) begin
        for (k = 0; k < ew; k++) add_byte(8'($urandom));
        used += ew;
      end
    end else begin
      while (used < len) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          add_byte(pbrd_pkg::FLAG_SKIP);
          used += 1;
        end else if (r < 50) begin
          add_byte(8'($urandom_range(8'h81, 8'hFF)));
          for (k = 0; k < ew; k++) add_byte(8'($urandom));
          used += 1 + ew;
        end else begin
          cap = (len - used - 1) / ew;
          if (cap < 1) cap = 1;
          if (cap > 128) cap = 128;
          n = $urandom_range(1, cap);
          if (r >= 97) n = 128;
          else if (r >= 90) n = $urandom_range(1, 8);
          add_byte(8'(n - 1));
          for (k = 0; k < n * ew; k++) add_byte(8'($urandom));
          used += 1 + n * ew;
        end
      end
    end
  endtask

  // Free-running result side: pop with random stalls after each word.
  initial begin : result_side
    int hold;
    pop  = 1'b0;
    hold = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) begin
        sb.match_word(elem_value, repeat_count, row_end);
        hold = idle_len();
      end
    end
  end

  initial begin : stimulus
    logic [15:0] rows;
    logic [1:0]  eb;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = pbrd_pkg::CFG_ROW_BYTES;
    cfg_data      = '0;
    push          = 1'b0;
    data_byte     = '0;
    quiet         = 1'b0;
    settings_used = 0;
    cur_rows      = '0;
    cur_eb        = 2'd1;
    sb            = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: raw rows with narrow elements, including an empty row
    set_config(16'd0, 2'd1);
    stream_q = '{8'h00, 8'h03, 8'h00, 8'hFF, 8'h5A};
    send_stream();

    // Directed: packet mode - skip, shortest run, literal ending the row,
    // skip that ends a row, longest run, literal packet past the row length
    drain();
    set_config(16'd16, 2'd1);
    stream_q = '{8'h05, pbrd_pkg::FLAG_SKIP, 8'hFF, 8'h11, 8'h00, 8'h22,
                 8'h01, pbrd_pkg::FLAG_SKIP,
                 8'h02, 8'h81, 8'hAB,
                 8'h02, 8'h01, 8'h33, 8'h44};
    send_stream();

    // Directed: odd raw length with wide elements reads one byte past the row
    drain();
    set_config(16'd4, 2'd2);
    stream_q = '{8'h03, 8'hAA, 8'hBB, 8'hCC, 8'hDD};
    send_stream();

    // Random phases over settings that hit the prefix and raw-mode boundaries
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin rows = 16'd0;     eb = 2'd1; end
        1:       begin rows = 16'd7;     eb = 2'd2; end
        2:       begin rows = 16'd8;     eb = 2'd1; end
        3:       begin rows = 16'd250;   eb = 2'd2; end
        4:       begin rows = 16'd251;   eb = 2'd1; end
        5:       begin rows = 16'hFFFF;  eb = 2'd2; end
        6:       begin rows = 16'd5;     eb = 2'd3; end
        7:       begin rows = 16'd200;   eb = 2'd0; end
        8:       begin rows = 16'($urandom_range(9, 250));     eb = 2'd3; end
        9:       begin rows = 16'($urandom_range(252, 65534)); eb = 2'd0; end
        10:      begin rows = 16'd1;     eb = 2'd2; end
        default: begin rows = 16'd16;    eb = 2'd1; end
      endcase
      drain();
      quiet = (p % 5 == 2);
      set_config(rows, eb);
      if (p == 3) begin
        write_reg(CFG_SPARE_LO, 16'($urandom));
        write_reg(CFG_SPARE_HI, 16'($urandom));
      end
      while (stream_q.size() < PHASE_BYTES) begin
        // some noise where a bad prefix cannot lock up a long row
        if (cur_rows <= pbrd_pkg::WIDE_PREFIX_MIN && $urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
        end else begin
          build_row();
        end
      end
      send_stream();
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d stream bytes, %0d words, %0d closed rows over %0d settings",
             sb.bytes_seen, sb.words_seen, sb.rows_closed, settings_used);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #10000000;
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
hdl/pbrd_pkg.sv
hdl/pbrd_parser.sv
hdl/pbrd_queue.sv
hdl/pbrd_assembler.sv
hdl/packbits_row_decoder_top.sv
hdl/pbrd_checker.sv
sim/packbits_row_decoder_top_tb.sv
